/* sv/gic_pkg.sv */
// Package: shared constants, register codes and types for the gamepad input conditioner.
package gic_pkg;

    localparam int NUM_INPUTS  = 11;
    localparam int SAMPLE_BITS = 12;

    localparam int REG_BITS    = 12;
    localparam int IDX_BITS    = 3;
    localparam int BTN_BITS    = 7;
    localparam int STATE_BITS  = 11;
    localparam int PIDX_BITS   = 4;
    localparam int RAW_BITS    = 11;
    localparam int CMP_BITS    = (SAMPLE_BITS > REG_BITS) ? SAMPLE_BITS : REG_BITS;

    localparam logic [REG_BITS-1:0] RST_FILTER_WINDOW = REG_BITS'(32);
    localparam logic [REG_BITS-1:0] RST_THRESH_LEFT   = REG_BITS'(3000);
    localparam logic [REG_BITS-1:0] RST_THRESH_RIGHT  = REG_BITS'(1000);
    localparam logic [REG_BITS-1:0] RST_THRESH_UP     = REG_BITS'(3000);
    localparam logic [REG_BITS-1:0] RST_THRESH_DOWN   = REG_BITS'(1000);

    typedef enum logic [IDX_BITS-1:0] {
        REG_FILTER_WINDOW = 3'd0,
        REG_THRESH_LEFT   = 3'd1,
        REG_THRESH_RIGHT  = 3'd2,
        REG_THRESH_UP     = 3'd3,
        REG_THRESH_DOWN   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic hi;
        logic lo;
    } t_dir;

endpackage

/* sv/gic_in_if.sv */
// Interface: poll item channel (two joystick samples and button levels).
interface gic_in_if
    import gic_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_x;
    logic [SAMPLE_BITS-1:0] sample_y;
    logic [BTN_BITS-1:0]    button_levels;

    modport source (output valid, output sample_x, output sample_y, output button_levels,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input button_levels,
                    output ready);
endinterface

/* sv/gic_out_if.sv */
// Interface: result channel (debounced state and lowest new press).
interface gic_out_if
    import gic_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [STATE_BITS-1:0] debounced_state;
    logic                  press_valid;
    logic [PIDX_BITS-1:0]  press_index;

    modport source (output valid, output debounced_state, output press_valid,
                    output press_index, input ready);
    modport sink   (input valid, input debounced_state, input press_valid,
                    input press_index, output ready);
endinterface

/* sv/gic_cfg_if.sv */
// Interface: configuration register write channel.
interface gic_cfg_if
    import gic_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [IDX_BITS-1:0] index;
    logic [REG_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/gic_axis.sv */
// Joystick axis: windowed hold of the sample and two-threshold direction decode.
module gic_axis
    import gic_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [REG_BITS-1:0]    i_window,
    input  logic [REG_BITS-1:0]    i_thr_hi,
    input  logic [REG_BITS-1:0]    i_thr_lo,
    output t_dir                   o_dir
);

    logic [SAMPLE_BITS-1:0] r_held;
    logic [SAMPLE_BITS-1:0] n_held;
    logic [SAMPLE_BITS-1:0] diff;

    always_comb begin
        diff = (r_held > i_sample) ? (r_held - i_sample) : (i_sample - r_held);
        n_held = (CMP_BITS'(diff) > CMP_BITS'(i_window)) ? i_sample : r_held;
        o_dir.hi = CMP_BITS'(n_held) > CMP_BITS'(i_thr_hi);
        o_dir.lo = !o_dir.hi && (CMP_BITS'(n_held) > CMP_BITS'(i_thr_lo));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_en) begin
            r_held <= n_held;
        end
    end

endmodule

/* sv/gamepad_input_conditioner.sv */
// Top level: gamepad input conditioner with axis hold, direction decode and debounce.
// Result: registered on the output register in the cycle after the input transfer.
// Throughput: one poll item per cycle; the output register decouples the two sides,
// so input ready drops only while a result waits and the sink is stalled.
// Reset: synchronous active low; clears held values and debounce state, sets the
// previous raw bits to all ones and loads register defaults.
module gamepad_input_conditioner
    import gic_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    gic_in_if.sink    i_in,
    gic_out_if.source o_out,
    gic_cfg_if.sink   i_cfg
);

    logic [REG_BITS-1:0] r_filter_window;
    logic [REG_BITS-1:0] r_thresh_left;
    logic [REG_BITS-1:0] r_thresh_right;
    logic [REG_BITS-1:0] r_thresh_up;
    logic [REG_BITS-1:0] r_thresh_down;

    logic [NUM_INPUTS-1:0] r_prev_raw;
    logic [NUM_INPUTS-1:0] r_deb;
    logic [NUM_INPUTS-1:0] n_deb;
    logic [NUM_INPUTS-1:0] raw;
    logic [NUM_INPUTS-1:0] rose;
    logic [RAW_BITS-1:0]   raw_all;
    logic [NUM_INPUTS+RAW_BITS-1:0]   raw_ext;
    logic [NUM_INPUTS+STATE_BITS-1:0] deb_ext;

    logic                  r_out_valid;
    logic [STATE_BITS-1:0] r_out_state;
    logic                  r_out_press;
    logic [PIDX_BITS-1:0]  r_out_index;
    logic [PIDX_BITS-1:0]  n_index;

    logic accept;
    t_dir dir_x;
    t_dir dir_y;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_window <= RST_FILTER_WINDOW;
            r_thresh_left   <= RST_THRESH_LEFT;
            r_thresh_right  <= RST_THRESH_RIGHT;
            r_thresh_up     <= RST_THRESH_UP;
            r_thresh_down   <= RST_THRESH_DOWN;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_FILTER_WINDOW: r_filter_window <= i_cfg.data;
                REG_THRESH_LEFT:   r_thresh_left   <= i_cfg.data;
                REG_THRESH_RIGHT:  r_thresh_right  <= i_cfg.data;
                REG_THRESH_UP:     r_thresh_up     <= i_cfg.data;
                REG_THRESH_DOWN:   r_thresh_down   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    gic_axis u_axis_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_sample (i_in.sample_x),
        .i_window (r_filter_window),
        .i_thr_hi (r_thresh_left),
        .i_thr_lo (r_thresh_right),
        .o_dir    (dir_x)
    );

    gic_axis u_axis_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_sample (i_in.sample_y),
        .i_window (r_filter_window),
        .i_thr_hi (r_thresh_up),
        .i_thr_lo (r_thresh_down),
        .o_dir    (dir_y)
    );

    always_comb begin
        raw_all = {~i_in.button_levels, dir_x.lo, dir_x.hi, dir_y.lo, dir_y.hi};
        raw_ext = {{NUM_INPUTS{1'b0}}, raw_all};
        raw     = raw_ext[NUM_INPUTS-1:0];
        n_deb   = (r_deb | (raw & r_prev_raw)) & (raw | r_prev_raw);
        rose    = n_deb & ~r_deb;
        n_index = '0;
        for (int i = NUM_INPUTS - 1; i >= 0; i--) begin
            if (rose[i]) begin
                n_index = PIDX_BITS'(i);
            end
        end
        deb_ext = {{STATE_BITS{1'b0}}, n_deb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw  <= '1;
            r_deb       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_prev_raw  <= raw;
                r_deb       <= n_deb;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_state <= deb_ext[STATE_BITS-1:0];
            r_out_press <= |rose;
            r_out_index <= n_index;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.debounced_state = r_out_state;
    assign o_out.press_valid     = r_out_press;
    assign o_out.press_index     = r_out_index;

endmodule
